FILE: hw/rtl/tssc_pkg.sv
// ----------------------------------------------------------------------------
// Text stream statistics counter package
// Shared types and constants for the front decoder, event queue and counter
// back end.
// ----------------------------------------------------------------------------
package tssc_pkg;

    localparam int OUT_BITS    = 40;
    localparam int CP_BITS     = 21;
    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_NORMAL  = 2'd1;
    localparam logic [1:0] KIND_NEWLINE = 2'd2;
    localparam logic [1:0] KIND_TAB     = 2'd3;

    localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
    localparam logic [7:0] BYTE_TAB     = 8'h09;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_CONT_LO = 8'h80;
    localparam logic [7:0] BYTE_CONT_HI = 8'hBF;
    localparam logic [3:0] TAB_STOP     = 4'd8;

    localparam logic [CP_BITS-1:0] CP_NBSP       = 21'h0000A0;
    localparam logic [CP_BITS-1:0] CP_OGHAM      = 21'h001680;
    localparam logic [CP_BITS-1:0] CP_SPACE_LO   = 21'h002000;
    localparam logic [CP_BITS-1:0] CP_SPACE_HI   = 21'h00200A;
    localparam logic [CP_BITS-1:0] CP_LINE_SEP   = 21'h002028;
    localparam logic [CP_BITS-1:0] CP_PARA_SEP   = 21'h002029;
    localparam logic [CP_BITS-1:0] CP_NNBSP      = 21'h00202F;
    localparam logic [CP_BITS-1:0] CP_MATH_SPACE = 21'h00205F;
    localparam logic [CP_BITS-1:0] CP_WORD_JOIN  = 21'h002060;
    localparam logic [CP_BITS-1:0] CP_IDEO_SPACE = 21'h003000;

    // One decoded event handed from the front to the back.
    typedef struct packed {
        logic       fin;
        logic [1:0] n_flush;
        logic [1:0] kind;
        logic       wide;
        logic       blank;
    } t_event;

    function automatic logic cp_blank(input logic [CP_BITS-1:0] cp);
        return (cp == CP_OGHAM) || ((cp >= CP_SPACE_LO) && (cp <= CP_SPACE_HI)) ||
               (cp == CP_LINE_SEP) || (cp == CP_PARA_SEP) || (cp == CP_MATH_SPACE) ||
               (cp == CP_IDEO_SPACE) || (cp == CP_NBSP) || (cp == CP_NNBSP) ||
               (cp == CP_WORD_JOIN);
    endfunction

endpackage

FILE: hw/rtl/tssc_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one stream word: an op code and a data byte.
// ----------------------------------------------------------------------------
interface tssc_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

FILE: hw/rtl/tssc_out_if.sv
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying the five counts of one finished stream.
// ----------------------------------------------------------------------------
interface tssc_out_if;
    logic        valid;
    logic        ready;
    logic [39:0] line_count;
    logic [39:0] word_count;
    logic [39:0] char_count;
    logic [39:0] byte_count;
    logic [39:0] max_line_width;

    modport source (output valid, output line_count, output word_count,
                    output char_count, output byte_count, output max_line_width,
                    input ready);
    modport sink   (input valid, input line_count, input word_count,
                    input char_count, input byte_count, input max_line_width,
                    output ready);
endinterface

FILE: hw/rtl/tssc_front.sv
// ----------------------------------------------------------------------------
// Front decoder
// Accepts stream words, runs the strict UTF-8 decoder and emits one event
// per word.
// ----------------------------------------------------------------------------
module tssc_front
    import tssc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_take,
    input  logic   i_op,
    input  logic   [7:0] i_data_byte,
    output t_event o_event
);

    logic [1:0]         r_need, n_need;
    logic [1:0]         r_held, n_held;
    logic [7:0]         r_lead, n_lead;
    logic [CP_BITS-1:0] r_cp, n_cp;

    logic [7:0]         lo;
    logic [7:0]         hi;
    logic               fits;
    logic [CP_BITS-1:0] cp_next;
    logic [7:0]         b;

    always_comb begin
        b       = i_data_byte;
        lo      = BYTE_CONT_LO;
        hi      = BYTE_CONT_HI;
        if (r_held == 2'd1) begin
            case (r_lead)
                8'hE0:   lo = 8'hA0;
                8'hED:   hi = 8'h9F;
                8'hF0:   lo = 8'h90;
                8'hF4:   hi = 8'h8F;
                default: ;
            endcase
        end
        fits    = (r_need != 2'd0) && (b >= lo) && (b <= hi);
        cp_next = {r_cp[CP_BITS-7:0], b[5:0]};

        n_need  = r_need;
        n_held  = r_held;
        n_lead  = r_lead;
        n_cp    = r_cp;
        o_event = '{fin: 1'b0, n_flush: 2'd0, kind: KIND_NONE, wide: 1'b0, blank: 1'b0};

        if (i_op == OP_FINISH) begin
            o_event.fin     = 1'b1;
            o_event.n_flush = r_held;
            n_need = '0;
            n_held = '0;
            n_lead = '0;
            n_cp   = '0;
        end else if (fits) begin
            if (r_need == 2'd1) begin
                o_event.kind  = KIND_NORMAL;
                o_event.wide  = !((cp_next < CP_NBSP) || (cp_next == CP_WORD_JOIN));
                o_event.blank = cp_blank(cp_next);
                n_need = '0;
                n_held = '0;
                n_lead = '0;
                n_cp   = '0;
            end else begin
                n_need = r_need - 2'd1;
                n_held = r_held + 2'd1;
                n_cp   = cp_next;
            end
        end else begin
            o_event.n_flush = (r_need != 2'd0) ? r_held : 2'd0;
            n_need = '0;
            n_held = '0;
            n_lead = '0;
            n_cp   = '0;
            if (b < BYTE_CONT_LO) begin
                if (b == BYTE_NEWLINE) begin
                    o_event.kind = KIND_NEWLINE;
                end else if (b == BYTE_TAB) begin
                    o_event.kind  = KIND_TAB;
                    o_event.blank = 1'b1;
                end else begin
                    o_event.kind  = KIND_NORMAL;
                    o_event.wide  = 1'b1;
                    o_event.blank = (b <= BYTE_SPACE);
                end
            end else if ((b >= 8'hC2) && (b <= 8'hDF)) begin
                n_need = 2'd1;
                n_held = 2'd1;
                n_lead = b;
                n_cp   = CP_BITS'(b[4:0]);
            end else if ((b >= 8'hE0) && (b <= 8'hEF)) begin
                n_need = 2'd2;
                n_held = 2'd1;
                n_lead = b;
                n_cp   = CP_BITS'(b[3:0]);
            end else if ((b >= 8'hF0) && (b <= 8'hF4)) begin
                n_need = 2'd3;
                n_held = 2'd1;
                n_lead = b;
                n_cp   = CP_BITS'(b[2:0]);
            end else begin
                o_event.kind = KIND_NORMAL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need <= '0;
            r_held <= '0;
            r_lead <= '0;
            r_cp   <= '0;
        end else if (i_take) begin
            r_need <= n_need;
            r_held <= n_held;
            r_lead <= n_lead;
            r_cp   <= n_cp;
        end
    end

endmodule

FILE: hw/rtl/tssc_queue.sv
// ----------------------------------------------------------------------------
// Event queue
// Short first-in first-out buffer between the front decoder and the back end.
// ----------------------------------------------------------------------------
module tssc_queue
    import tssc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_event,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_event o_event
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_event              r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    assign o_full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_event = r_mem[r_rd_ptr];

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/tssc_back.sv
// ----------------------------------------------------------------------------
// Counter back end
// Applies decoded events to the saturating counters and holds the finished
// counts in the output register.
// ----------------------------------------------------------------------------
module tssc_back
    import tssc_pkg::*;
#(
    parameter int COUNT_BITS = 40
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_empty,
    input  t_event i_event,
    output logic   o_pop,
    tssc_out_if.source o_out
);

    localparam int SUM_BITS = COUNT_BITS + 1;

    logic [COUNT_BITS-1:0] r_lines, r_words, r_chars, r_bytes, r_widest, r_cw;
    logic [COUNT_BITS-1:0] n_lines, n_words, n_chars, n_bytes, n_widest, n_cw;
    logic                  r_in_word, n_in_word;
    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_out_lines, r_out_words, r_out_chars, r_out_bytes;
    logic [OUT_BITS-1:0]   r_out_widest;

    logic                  out_free;
    logic                  flushing;
    logic                  iw_flush;
    logic                  word_start;
    logic [2:0]            char_inc;
    logic [3:0]            tab_inc;
    logic [COUNT_BITS-1:0] line_max;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [3:0] inc);
        logic [SUM_BITS-1:0] sum;
        sum = SUM_BITS'(a) + SUM_BITS'(inc);
        return sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    endfunction

    function automatic logic [OUT_BITS-1:0] to_out(input logic [COUNT_BITS-1:0] v);
        logic [63:0] wide_v;
        wide_v = 64'(v);
        return wide_v[OUT_BITS-1:0];
    endfunction

    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = !i_empty && (!i_event.fin || out_free);

    always_comb begin
        flushing   = (i_event.n_flush != 2'd0);
        iw_flush   = r_in_word || flushing;
        word_start = (flushing && !r_in_word) ||
                     ((i_event.kind == KIND_NORMAL) && !i_event.blank && !iw_flush);
        char_inc   = {1'b0, i_event.n_flush} + {2'b0, (i_event.kind != KIND_NONE)};
        tab_inc    = TAB_STOP - {1'b0, r_cw[2:0]};
        line_max   = (r_cw > r_widest) ? r_cw : r_widest;

        n_lines   = r_lines;
        n_words   = word_start ? sat_add(r_words, 4'd1) : r_words;
        n_chars   = sat_add(r_chars, {1'b0, char_inc});
        n_bytes   = i_event.fin ? r_bytes : sat_add(r_bytes, 4'd1);
        n_widest  = r_widest;
        n_cw      = r_cw;
        n_in_word = iw_flush;

        case (i_event.kind)
            KIND_NORMAL: begin
                n_cw      = sat_add(r_cw, {3'b0, i_event.wide});
                n_in_word = !i_event.blank;
            end
            KIND_TAB: begin
                n_cw      = sat_add(r_cw, tab_inc);
                n_in_word = 1'b0;
            end
            KIND_NEWLINE: begin
                n_lines   = sat_add(r_lines, 4'd1);
                n_widest  = line_max;
                n_cw      = '0;
                n_in_word = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines     <= '0;
            r_words     <= '0;
            r_chars     <= '0;
            r_bytes     <= '0;
            r_widest    <= '0;
            r_cw        <= '0;
            r_in_word   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_event.fin) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_event.fin) begin
                    r_lines     <= '0;
                    r_words     <= '0;
                    r_chars     <= '0;
                    r_bytes     <= '0;
                    r_widest    <= '0;
                    r_cw        <= '0;
                    r_in_word   <= 1'b0;
                end else begin
                    r_lines     <= n_lines;
                    r_words     <= n_words;
                    r_chars     <= n_chars;
                    r_bytes     <= n_bytes;
                    r_widest    <= n_widest;
                    r_cw        <= n_cw;
                    r_in_word   <= n_in_word;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_event.fin) begin
            r_out_lines  <= to_out(r_lines);
            r_out_words  <= to_out(n_words);
            r_out_chars  <= to_out(n_chars);
            r_out_bytes  <= to_out(r_bytes);
            r_out_widest <= to_out(line_max);
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.line_count     = r_out_lines;
    assign o_out.word_count     = r_out_words;
    assign o_out.char_count     = r_out_chars;
    assign o_out.byte_count     = r_out_bytes;
    assign o_out.max_line_width = r_out_widest;

endmodule

FILE: hw/rtl/text_stream_statistics_counter_core.sv
// ----------------------------------------------------------------------------
// Text stream statistics counter
// Counts lines, words, characters, bytes and the widest line of a UTF-8 stream.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle: a data byte, or a finish word that
// returns the five counts and clears the counters. A data byte passes through
// the decoder and a two-entry event queue and updates the counters when it
// leaves the queue; a finish word loads the output register when it reaches
// the head of the queue and that register is free, and otherwise waits there
// until the register is emptied. Input is held off only while the queue is
// full, which happens when a finish word waits for the output register to be
// emptied. Counters are COUNT_BITS wide and saturate; outputs show 40 bits.
module text_stream_statistics_counter_core
    import tssc_pkg::*;
#(
    parameter int COUNT_BITS = 40
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tssc_in_if.sink    i_in,
    tssc_out_if.source o_out
);

    t_event front_event;
    t_event head_event;
    logic   take;
    logic   q_full;
    logic   q_empty;
    logic   pop;

    assign i_in.ready = !q_full;
    assign take       = i_in.valid && !q_full;

    tssc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_op        (i_in.op),
        .i_data_byte (i_in.data_byte),
        .o_event     (front_event)
    );

    tssc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_event (front_event),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_event (head_event)
    );

    tssc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_event (head_event),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Text stream statistics counter testbench
// Feeds byte streams, each closed by a finish word, into the counter. A
// scoreboard class decodes every accepted word itself and checks each set of
// five counts that the block returns. Sender and receiver idle and stall at
// random.
// ----------------------------------------------------------------------------
import tssc_pkg::*;

typedef struct packed {
    logic [39:0] line_count;
    logic [39:0] word_count;
    logic [39:0] char_count;
    logic [39:0] byte_count;
    logic [39:0] max_line_width;
} t_stream_counts;

class stream_stats_board;
    logic [39:0]    lines_seen;
    logic [39:0]    words_seen;
    logic [39:0]    chars_seen;
    logic [39:0]    bytes_seen;
    logic [39:0]    widest_line;
    logic [39:0]    line_width;
    bit             in_word;
    logic [20:0]    code_point;
    int unsigned    cont_left;
    int unsigned    held_count;
    logic [7:0]     lead_byte;
    t_stream_counts expected_counts[$];
    int unsigned    mismatches;

    function new();
        clear_stream();
        mismatches = 0;
    endfunction

    function logic [39:0] sat_add(logic [39:0] a, logic [39:0] b);
        logic [40:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[40] ? {40{1'b1}} : sum[39:0];
    endfunction

    function void clear_held();
        code_point = '0;
        cont_left  = 0;
        held_count = 0;
        lead_byte  = '0;
    endfunction

    function void clear_stream();
        lines_seen  = '0;
        words_seen  = '0;
        chars_seen  = '0;
        bytes_seen  = '0;
        widest_line = '0;
        line_width  = '0;
        in_word     = 1'b0;
        clear_held();
    endfunction

    function void take_glyph(logic [39:0] width, bit blank);
        chars_seen = sat_add(chars_seen, 40'd1);
        line_width = sat_add(line_width, width);
        if (blank) begin
            in_word = 1'b0;
        end else if (!in_word) begin
            words_seen = sat_add(words_seen, 40'd1);
            in_word = 1'b1;
        end
    endfunction

    function bit is_blank_cp(logic [20:0] cp);
        return (cp == CP_NBSP) || (cp == CP_OGHAM) ||
               ((cp >= CP_SPACE_LO) && (cp <= CP_SPACE_HI)) ||
               (cp == CP_LINE_SEP) || (cp == CP_PARA_SEP) || (cp == CP_NNBSP) ||
               (cp == CP_MATH_SPACE) || (cp == CP_WORD_JOIN) || (cp == CP_IDEO_SPACE);
    endfunction

    // Every byte of an unfinished sequence becomes a zero-width non-blank character.
    function void flush_held();
        repeat (held_count) take_glyph(40'd0, 1'b0);
        clear_held();
    endfunction

    function void take_ascii(logic [7:0] b);
        if (b == BYTE_NEWLINE) begin
            chars_seen = sat_add(chars_seen, 40'd1);
            lines_seen = sat_add(lines_seen, 40'd1);
            if (line_width > widest_line) widest_line = line_width;
            line_width = '0;
            in_word = 1'b0;
        end else if (b == BYTE_TAB) begin
            take_glyph(40'd8 - {37'd0, line_width[2:0]}, 1'b1);
        end else begin
            take_glyph(40'd1, b <= BYTE_SPACE);
        end
    endfunction

    function void take_fresh(logic [7:0] b);
        if (b < BYTE_CONT_LO) begin
            take_ascii(b);
            return;
        end
        if (b >= 8'hC2 && b <= 8'hDF) begin
            cont_left  = 1;
            code_point = {16'd0, b[4:0]};
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            cont_left  = 2;
            code_point = {17'd0, b[3:0]};
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            cont_left  = 3;
            code_point = {18'd0, b[2:0]};
        end else begin
            take_glyph(40'd0, 1'b0);
            return;
        end
        held_count = 1;
        lead_byte  = b;
    endfunction

    function void take_byte(logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        bytes_seen = sat_add(bytes_seen, 40'd1);
        if (cont_left > 0) begin
            lo = BYTE_CONT_LO;
            hi = BYTE_CONT_HI;
            if (held_count == 1) begin
                case (lead_byte)
                    8'hE0: lo = 8'hA0;
                    8'hED: hi = 8'h9F;
                    8'hF0: lo = 8'h90;
                    8'hF4: hi = 8'h8F;
                    default: ;
                endcase
            end
            if (b >= lo && b <= hi) begin
                code_point = {code_point[14:0], b[5:0]};
                held_count++;
                cont_left--;
                if (cont_left == 0) begin
                    take_glyph((code_point < CP_NBSP || code_point == CP_WORD_JOIN) ?
                               40'd0 : 40'd1, is_blank_cp(code_point));
                    clear_held();
                end
                return;
            end
            flush_held();
        end
        take_fresh(b);
    endfunction

    function void note_input(logic op, logic [7:0] b);
        t_stream_counts counts;
        if (op == OP_DATA) begin
            take_byte(b);
            return;
        end
        flush_held();
        if (line_width > widest_line) widest_line = line_width;
        counts.line_count     = lines_seen;
        counts.word_count     = words_seen;
        counts.char_count     = chars_seen;
        counts.byte_count     = bytes_seen;
        counts.max_line_width = widest_line;
        expected_counts.push_back(counts);
        clear_stream();
    endfunction

    function void compare_field(string name, logic [39:0] want, logic [39:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function void check_counts(t_stream_counts got);
        t_stream_counts want;
        if (expected_counts.size() == 0) begin
            $error("counts returned with no finish word pending");
            mismatches++;
            return;
        end
        want = expected_counts.pop_front();
        compare_field("line_count", want.line_count, got.line_count);
        compare_field("word_count", want.word_count, got.word_count);
        compare_field("char_count", want.char_count, got.char_count);
        compare_field("byte_count", want.byte_count, got.byte_count);
        compare_field("max_line_width", want.max_line_width, got.max_line_width);
    endfunction

    function int unsigned pending();
        return expected_counts.size();
    endfunction
endclass

module tb;
    logic              i_clk;
    logic              i_rst_n;
    tssc_in_if         in_if();
    tssc_out_if        out_if();
    stream_stats_board board;
    int unsigned       burst_left;
    int unsigned       words_sent;
    int unsigned       stall_mode = 0;
    int unsigned       stall_left = 0;
    int unsigned       stall_tick = 0;
    logic [7:0]        stream_bytes[$];
    logic [20:0]       odd_points[14] = '{21'h0000A0, 21'h001680, 21'h002000, 21'h002007,
                                          21'h00200A, 21'h00200B, 21'h002028, 21'h002029,
                                          21'h00202F, 21'h00205F, 21'h002060, 21'h003000,
                                          21'h00009F, 21'h000085};

    text_stream_statistics_counter_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20 * 400000);
        $display("FAIL text_stream_statistics_counter_core");
        $finish;
    end

    always @(posedge i_clk) begin
        t_stream_counts seen;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen.line_count     = out_if.line_count;
            seen.word_count     = out_if.word_count;
            seen.char_count     = out_if.char_count;
            seen.byte_count     = out_if.byte_count;
            seen.max_line_width = out_if.max_line_width;
            board.check_counts(seen);
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 300);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= ($urandom_range(0, 1) == 1);
            2: out_if.ready <= (stall_tick % 4 == 0);
            default: out_if.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic send_word(input logic op, input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_if.valid     <= 1'b0;
                in_if.data_byte <= 8'($urandom_range(0, 255));
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.data_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        board.note_input(op, b);
        words_sent++;
    endtask

    task automatic send_stream();
        foreach (stream_bytes[i]) send_word(OP_DATA, stream_bytes[i]);
        send_word(OP_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat ($urandom_range(1, 10)) @(posedge i_clk);
    endtask

    function automatic void push_code_point(logic [20:0] cp);
        if (cp < 21'h80) begin
            stream_bytes.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            stream_bytes.push_back({3'b110, cp[10:6]});
            stream_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            stream_bytes.push_back({4'b1110, cp[15:12]});
            stream_bytes.push_back({2'b10, cp[11:6]});
            stream_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            stream_bytes.push_back({5'b11110, cp[20:18]});
            stream_bytes.push_back({2'b10, cp[17:12]});
            stream_bytes.push_back({2'b10, cp[11:6]});
            stream_bytes.push_back({2'b10, cp[5:0]});
        end
    endfunction

    function automatic logic [20:0] pick_code_point(int unsigned len);
        logic [20:0] cp;
        logic [20:0] edge2[4] = '{21'h80, 21'h9F, 21'hA0, 21'h7FF};
        logic [20:0] edge3[6] = '{21'h800, 21'hFFF, 21'h1000, 21'hD7FF, 21'hE000, 21'hFFFF};
        logic [20:0] edge4[6] = '{21'h10000, 21'h3FFFF, 21'h40000, 21'hFFFFF,
                                  21'h100000, 21'h10FFFF};
        bit          at_edge;
        at_edge = ($urandom_range(0, 2) == 0);
        if (len == 2) begin
            cp = at_edge ? edge2[$urandom_range(0, 3)]
                         : 21'($urandom_range(21'h80, 21'h7FF));
        end else if (len == 3) begin
            if (at_edge) begin
                cp = edge3[$urandom_range(0, 5)];
            end else begin
                do cp = 21'($urandom_range(21'h800, 21'hFFFF));
                while (cp >= 21'hD800 && cp <= 21'hDFFF);
            end
        end else begin
            cp = at_edge ? edge4[$urandom_range(0, 5)]
                         : 21'($urandom_range(21'h10000, 21'h10FFFF));
        end
        return cp;
    endfunction

    function automatic void push_broken();
        int unsigned len;
        int unsigned keep;
        int unsigned start;
        logic [7:0]  lead;
        len   = $urandom_range(2, 4);
        start = stream_bytes.size();
        push_code_point(pick_code_point(len));
        keep = $urandom_range(1, len - 1);
        while (stream_bytes.size() > start + keep) void'(stream_bytes.pop_back());
        lead = stream_bytes[start];
        case ($urandom_range(0, 3))
            0: begin
                if (keep == 1 && lead == 8'hE0)
                    stream_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
                else if (keep == 1 && lead == 8'hED)
                    stream_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                else if (keep == 1 && lead == 8'hF0)
                    stream_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
                else if (keep == 1 && lead == 8'hF4)
                    stream_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
                else
                    stream_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
            end
            1: stream_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
            2: stream_bytes.push_back(8'($urandom_range(8'h00, 8'hFF)));
            default: ;
        endcase
    endfunction

    function automatic void push_token();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)      stream_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
        else if (r < 36) stream_bytes.push_back(BYTE_SPACE);
        else if (r < 40) stream_bytes.push_back(BYTE_NEWLINE);
        else if (r < 44) stream_bytes.push_back(BYTE_TAB);
        else if (r < 48) stream_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
        else if (r < 58) push_code_point(pick_code_point(2));
        else if (r < 68) push_code_point(pick_code_point(3));
        else if (r < 74) push_code_point(pick_code_point(4));
        else if (r < 82) push_code_point(odd_points[$urandom_range(0, 13)]);
        else if (r < 88) stream_bytes.push_back(8'(($urandom_range(0, 1) == 1) ?
                                                   $urandom_range(8'h80, 8'hC1) :
                                                   $urandom_range(8'hF5, 8'hFF)));
        else             push_broken();
    endfunction

    task automatic send_random_stream();
        stream_bytes.delete();
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(0, 40)) stream_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 20)) push_token();
        end
        send_stream();
    endtask

    initial begin
        board           = new();
        burst_left      = 0;
        words_sent      = 0;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.op        <= OP_DATA;
        in_if.data_byte <= 8'h00;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // An empty stream, then ASCII controls, tab, newline and lone invalid bytes.
        stream_bytes.delete();
        send_stream();
        stream_bytes = {8'h41, BYTE_TAB, BYTE_SPACE, 8'h00, 8'h7F, BYTE_NEWLINE,
                        8'hFF, 8'hC1, 8'h80};
        send_stream();
        // Blank and zero-width code points, the highest code point, a broken
        // second byte and a sequence cut short by the finish word.
        stream_bytes = {8'hC2, 8'hA0, 8'hE2, 8'h80, 8'hAF, 8'hE2, 8'h81, 8'hA0,
                        8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hE0, 8'h9F, 8'hF0, 8'h90};
        send_stream();
        wait_drained();

        while (words_sent < 850) begin
            send_random_stream();
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (board.mismatches == 0) begin
            $display("PASS text_stream_statistics_counter_core");
        end else begin
            $display("FAIL text_stream_statistics_counter_core");
        end
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/tssc_pkg.sv
hw/rtl/tssc_in_if.sv
hw/rtl/tssc_out_if.sv
hw/rtl/tssc_front.sv
hw/rtl/tssc_queue.sv
hw/rtl/tssc_back.sv
hw/rtl/text_stream_statistics_counter_core.sv
tb/sv/tb.sv
